@@ sv/priority_counting_semaphore_assert.svh @@
// Assertion macros used by the priority counting semaphore datapath.
`ifndef PRIORITY_COUNTING_SEMAPHORE_ASSERT_SVH
`define PRIORITY_COUNTING_SEMAPHORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PCS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcs_pkg.sv @@
// Types and constants shared by the priority counting semaphore modules.
package pcs_pkg;

  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [COUNT_W-1:0] INIT_COUNT_RST = 8'd1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_COUNT = '0;

  typedef enum logic [1:0] {
    OP_DOWN = 2'd0,
    OP_TRY  = 2'd1,
    OP_UP   = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_REFUSED = 3'd2,
    ST_FULL    = 3'd3,
    ST_WOKE    = 3'd4,
    ST_RAISED  = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] requester_id;
    logic [5:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] woken_id;
    logic [7:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

@@ sv/priority_counting_semaphore.sv @@
// Top level of the priority-ordered counting semaphore with its register port.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   request | in        | in_valid_i / in_ready_o   | in_data_i  (req_t)
//   result  | out       | out_valid_o / out_ready_i | out_data_o (rsp_t)
//   config  | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Each request is handled in a capture step and then an execute step, in
// which the shift-register queue inserts or pops and the count updates.
// A new request is accepted while the previous result waits in the output
// register; execution holds only while that register is full and not read.
// Reset loads the count with one and empties the queue; no clearing pass.
// Writing initial_count reloads the count and empties the queue.
module priority_counting_semaphore #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pcs_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcs_pkg::rsp_t                 out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [pcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [pcs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import pcs_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         dp_status;
  logic               reg_hit;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_rdata;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_INITIAL_COUNT;
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? PDATA_W'(cfg_rdata) : '0;

  pcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  pcs_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[COUNT_W-1:0]),
    .cfg_rdata_o (cfg_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/pcs_ctrl.sv @@
// Controller state machine: sequences capture and execution of one request.
module pcs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pcs_pkg::dp_status_t    dp_status_i,
  output pcs_pkg::ctrl_cmd_t     cmd_o
);
  import pcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be free, or be emptied in this cycle.
        if (!dp_status_i.out_stall) begin
          cmd_o.execute = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/pcs_dp.sv @@
// Datapath: unit count, sorted shift-register wait queue and result register.
`include "priority_counting_semaphore_assert.svh"

module pcs_dp #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcs_pkg::ctrl_cmd_t              cmd_i,
  output pcs_pkg::dp_status_t             status_o,
  input  pcs_pkg::req_t                   req_i,
  input  logic                            cfg_we_i,
  input  logic [pcs_pkg::COUNT_W-1:0]     cfg_wdata_i,
  output logic [pcs_pkg::COUNT_W-1:0]     cfg_rdata_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pcs_pkg::rsp_t                   out_data_o
);
  import pcs_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  req_t                     req_q;
  logic [COUNT_W-1:0]       init_count_q;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [ID_BITS-1:0]       ids_q [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prios_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       ids_d [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prios_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   at_or_after;
  logic [ID_BITS-1:0]       req_id;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic                     do_push, do_pop;
  status_e                  status;
  logic [7:0]               woken;
  rsp_t                     out_q;
  logic                     out_valid_q;

  assign req_id   = ID_BITS'(req_q.requester_id);
  assign req_prio = PRIORITY_BITS'(req_q.priority_req);

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign cfg_rdata_o        = init_count_q;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Request decode and count/fill update.
  always_comb begin
    count_d = count_q;
    fill_d  = fill_q;
    do_push = 1'b0;
    do_pop  = 1'b0;
    status  = ST_REFUSED;
    woken   = '0;
    case (op_e'(req_q.op))
      OP_DOWN: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
          status  = ST_GRANTED;
        end else if (fill_q != FILL_FULL) begin
          do_push = 1'b1;
          fill_d  = fill_q + 1'b1;
          status  = ST_QUEUED;
        end else begin
          status = ST_FULL;
        end
      end
      OP_TRY: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
          status  = ST_GRANTED;
        end
      end
      OP_UP: begin
        if (fill_q != '0) begin
          do_pop = 1'b1;
          fill_d = fill_q - 1'b1;
          status = ST_WOKE;
          woken  = 8'(ids_q[0]);
        end else begin
          if (count_q != COUNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          status = ST_RAISED;
        end
      end
      default: begin
        status = ST_REFUSED;
      end
    endcase
  end

  // Every cell compares against the new priority at once. Because the queue
  // is sorted, the cells that lie at or after the insert point form a
  // contiguous run that reaches the end of the queue.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (FILL_W'(i) < fill_q) begin
        at_or_after[i] = req_prio > prios_q[i];
      end else begin
        at_or_after[i] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_d[i]   = ids_q[i];
      prios_d[i] = prios_q[i];
      if (do_push) begin
        if (i > 0 && at_or_after[i-1]) begin
          ids_d[i]   = ids_q[i-1];
          prios_d[i] = prios_q[i-1];
        end else if (at_or_after[i]) begin
          ids_d[i]   = req_id;
          prios_d[i] = req_prio;
        end
      end else if (do_pop && i < QUEUE_DEPTH - 1) begin
        ids_d[i]   = ids_q[i+1];
        prios_d[i] = prios_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && (do_push || do_pop)) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ids_q[i]   <= ids_d[i];
        prios_q[i] <= prios_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count_q <= INIT_COUNT_RST;
      count_q      <= INIT_COUNT_RST;
      fill_q       <= '0;
    end else if (cfg_we_i) begin
      init_count_q <= cfg_wdata_i;
      count_q      <= cfg_wdata_i;
      fill_q       <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_q.status     <= status;
      out_q.woken_id   <= woken;
      out_q.free_count <= count_d;
    end
  end

  `PCS_ASSERT(a_fill_bound, fill_q <= FILL_FULL, "queue fill exceeds depth")
  `PCS_ASSERT(a_exec_free, !(cmd_i.execute && status_o.out_stall),
              "result overwritten while still waiting")
  `PCS_ASSERT_NEXT(a_pop_fill, cmd_i.execute && do_pop && !cfg_we_i,
                   fill_q == $past(fill_q) - 1'b1, "wake did not shrink the queue")

  for (genvar g = 0; g < QUEUE_DEPTH - 1; g++) begin : g_sorted
    `PCS_ASSERT(a_sorted, (FILL_W'(g + 1) >= fill_q) || (prios_q[g] >= prios_q[g+1]),
                "wait queue out of priority order")
  end

endmodule
